// ===== rtl/core/rsl_pkg.sv =====
// Shared constants, types and codes of the radial spotlight luminance block.
`default_nettype none
package rsl_pkg;

    // Field widths
    localparam int unsigned COORD_BITS = 12;
    localparam int unsigned CTR_W      = 14;
    localparam int unsigned LUMA_W     = 16;

    // Configuration port
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = CTR_W;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_COL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_ROW = 1'd1;

    // Distance datapath: difference, magnitude, square and radicand
    localparam int unsigned DIFF_W  = CTR_W + 1;
    localparam int unsigned ABS_W   = DIFF_W - 1;
    localparam int unsigned SQ_W    = 2 * ABS_W;
    localparam int unsigned DSQ_W   = SQ_W + 1;
    localparam int unsigned FRAC_SH = 8;
    localparam int unsigned RAD_W   = 2 * ((DSQ_W + FRAC_SH + 1) / 2);
    localparam int unsigned SQ_STEPS = RAD_W / 2;
    localparam int unsigned ROOT_W  = SQ_STEPS;
    localparam int unsigned REM_W   = ROOT_W + 1;

    // Falloff rule
    localparam int unsigned FALLOFF_RADIUS = 160;
    localparam int unsigned D_LIM   = FALLOFF_RADIUS * 16;
    localparam int unsigned DL_W    = $clog2(D_LIM + 1);
    localparam int unsigned DROP_SH = 9;
    localparam int unsigned DROP_BIAS = 24;
    localparam int unsigned NUM_W   = DL_W + DROP_SH + 1;

    // Divide by 25 through a reciprocal: exact for numerators below 2^30
    localparam int unsigned RECIP_W = 28;
    localparam int unsigned DIV25_SH = 32;
    localparam logic [RECIP_W-1:0] DIV25_RECIP = 28'd171798692;
    localparam int unsigned PROD_W  = NUM_W + RECIP_W;
    localparam int unsigned DROP_W  = PROD_W - DIV25_SH;

    // Factor in Q1.16
    localparam int unsigned FAC_W    = 17;
    localparam int unsigned FAC_FRAC = 16;
    localparam int unsigned FAC_ONE  = 65536;
    localparam int unsigned FAR_FACTOR = 13107;
    localparam int unsigned EXT_W   = (DROP_W > FAC_W) ? DROP_W : FAC_W;
    localparam int unsigned SCL_W   = LUMA_W + FAC_W;

    // Register stages: three in front, one per root bit, three at the back
    localparam int unsigned PIPE_DEPTH = 3 + SQ_STEPS + 3;
    localparam int unsigned CNT_W      = $clog2(PIPE_DEPTH + 1);

    // Item moving through the square root cells
    typedef struct packed {
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
        logic [LUMA_W-1:0] luma;
    } t_sq_data;

endpackage
`default_nettype wire

// ===== rtl/core/rsl_in_if.sv =====
// Input channel: pixel coordinates and luminance with valid/ready.
`default_nettype none
interface rsl_in_if;
    import rsl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pix_col;
    logic [COORD_BITS-1:0] pix_row;
    logic [LUMA_W-1:0]     luma_in;

    modport source (output valid, output pix_col, output pix_row, output luma_in,
                    input ready);
    modport sink   (input valid, input pix_col, input pix_row, input luma_in,
                    output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rsl_out_if.sv =====
// Output channel: attenuated luminance with valid/ready.
`default_nettype none
interface rsl_out_if;
    import rsl_pkg::*;

    logic              valid;
    logic              ready;
    logic [LUMA_W-1:0] luma_out;

    modport source (output valid, output luma_out, input ready);
    modport sink   (input valid, input luma_out, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/rsl_sqrt_cell.sv =====
// One square root cell: settles one root bit and hands the item to its neighbor.
`default_nettype none
module rsl_sqrt_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_vld,
    output logic                   o_rdy,
    input  wire rsl_pkg::t_sq_data i_data,
    output logic                   o_vld,
    input  wire logic              i_rdy,
    output rsl_pkg::t_sq_data      o_data
);
    import rsl_pkg::*;

    logic              r_vld;
    t_sq_data          r_data;
    t_sq_data          n_data;
    logic [REM_W+1:0]  w_rem;
    logic [REM_W+1:0]  w_trial;
    logic [REM_W+1:0]  w_diff;
    logic              w_ld;

    // Shift in the next two radicand bits and try the new root bit
    always_comb begin
        w_rem   = {i_data.rem, i_data.rad[RAD_W-1 -: 2]};
        w_trial = (REM_W + 2)'({i_data.root, 2'b01});
        w_diff  = w_rem - w_trial;
        n_data      = i_data;
        n_data.rad  = {i_data.rad[RAD_W-3:0], 2'b00};
        if (w_rem >= w_trial) begin
            n_data.rem  = w_diff[REM_W-1:0];
            n_data.root = {i_data.root[ROOT_W-2:0], 1'b1};
        end else begin
            n_data.rem  = w_rem[REM_W-1:0];
            n_data.root = {i_data.root[ROOT_W-2:0], 1'b0};
        end
    end

    assign w_ld  = !r_vld || i_rdy;
    assign o_rdy = w_ld;

    // Advance when the neighbor takes the held item or the cell is empty
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_ld) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ld && i_vld) begin
            r_data <= n_data;
        end
    end

    assign o_vld  = r_vld;
    assign o_data = r_data;
endmodule
`default_nettype wire

// ===== rtl/core/rsl_front.sv =====
// Front stages: offsets from the center, squares and the scaled radicand.
`default_nettype none
module rsl_front (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic signed [rsl_pkg::CTR_W-1:0]  i_center_col,
    input  wire logic signed [rsl_pkg::CTR_W-1:0]  i_center_row,
    input  wire logic                              i_vld,
    output logic                                   o_rdy,
    input  wire logic [rsl_pkg::COORD_BITS-1:0]    i_col,
    input  wire logic [rsl_pkg::COORD_BITS-1:0]    i_row,
    input  wire logic [rsl_pkg::LUMA_W-1:0]        i_luma,
    output logic                                   o_vld,
    input  wire logic                              i_rdy,
    output rsl_pkg::t_sq_data                      o_data
);
    import rsl_pkg::*;

    logic              r_vld_a, r_vld_b, r_vld_c;
    logic              w_ld_a, w_ld_b, w_ld_c;
    logic [ABS_W-1:0]  r_ax, r_ay;
    logic [SQ_W-1:0]   r_sqx, r_sqy;
    logic [DSQ_W-1:0]  r_dsq;
    logic [LUMA_W-1:0] r_luma_a, r_luma_b, r_luma_c;
    logic [DIFF_W-1:0] w_dx, w_dy;
    logic [DIFF_W-1:0] w_mx, w_my;

    // Signed offsets and their magnitudes
    always_comb begin
        w_dx = {{(DIFF_W-COORD_BITS){1'b0}}, i_col}
             - {{(DIFF_W-CTR_W){i_center_col[CTR_W-1]}}, i_center_col};
        w_dy = {{(DIFF_W-COORD_BITS){1'b0}}, i_row}
             - {{(DIFF_W-CTR_W){i_center_row[CTR_W-1]}}, i_center_row};
        w_mx = w_dx[DIFF_W-1] ? (~w_dx + DIFF_W'(1)) : w_dx;
        w_my = w_dy[DIFF_W-1] ? (~w_dy + DIFF_W'(1)) : w_dy;
    end

    assign w_ld_c = !r_vld_c || i_rdy;
    assign w_ld_b = !r_vld_b || w_ld_c;
    assign w_ld_a = !r_vld_a || w_ld_b;
    assign o_rdy  = w_ld_a;

    // Valid bits of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
        end else begin
            if (w_ld_a) r_vld_a <= i_vld;
            if (w_ld_b) r_vld_b <= r_vld_a;
            if (w_ld_c) r_vld_c <= r_vld_b;
        end
    end

    // Hold magnitudes
    always_ff @(posedge i_clk) begin
        if (w_ld_a && i_vld) begin
            r_ax     <= w_mx[ABS_W-1:0];
            r_ay     <= w_my[ABS_W-1:0];
            r_luma_a <= i_luma;
        end
    end

    // Square each magnitude
    always_ff @(posedge i_clk) begin
        if (w_ld_b && r_vld_a) begin
            r_sqx    <= SQ_W'(r_ax) * SQ_W'(r_ax);
            r_sqy    <= SQ_W'(r_ay) * SQ_W'(r_ay);
            r_luma_b <= r_luma_a;
        end
    end

    // Sum of squares
    always_ff @(posedge i_clk) begin
        if (w_ld_c && r_vld_b) begin
            r_dsq    <= DSQ_W'(r_sqx) + DSQ_W'(r_sqy);
            r_luma_c <= r_luma_b;
        end
    end

    // Radicand carries four fraction bits in the root
    always_comb begin
        o_data.rad  = RAD_W'({r_dsq, {FRAC_SH{1'b0}}});
        o_data.rem  = '0;
        o_data.root = '0;
        o_data.luma = r_luma_c;
    end

    assign o_vld = r_vld_c;
endmodule
`default_nettype wire

// ===== rtl/core/rsl_back.sv =====
// Back stages: falloff factor from the distance and the scaled luminance.
`default_nettype none
module rsl_back (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_vld,
    output logic                                o_rdy,
    input  wire logic [rsl_pkg::ROOT_W-1:0]     i_dist,
    input  wire logic [rsl_pkg::LUMA_W-1:0]     i_luma,
    output logic                                o_vld,
    input  wire logic                           i_rdy,
    output logic [rsl_pkg::LUMA_W-1:0]          o_luma
);
    import rsl_pkg::*;

    logic              r_vld_d, r_vld_e, r_vld_f;
    logic              w_ld_d, w_ld_e, w_ld_f;
    logic [PROD_W-1:0] r_prod;
    logic              r_near;
    logic [LUMA_W-1:0] r_luma_d, r_luma_e;
    logic [FAC_W-1:0]  r_factor;
    logic [LUMA_W-1:0] r_out;
    logic [NUM_W-1:0]  w_num;
    logic              w_near;
    logic [EXT_W-1:0]  w_drop;
    logic [EXT_W-1:0]  w_diff;
    logic [FAC_W-1:0]  n_factor;
    logic [SCL_W-1:0]  w_scaled;

    // Numerator of the ceiling divide by 25
    assign w_near = (i_dist <= ROOT_W'(D_LIM));
    assign w_num  = NUM_W'({i_dist[DL_W-1:0], {DROP_SH{1'b0}}}) + NUM_W'(DROP_BIAS);

    // Drop is the product's high part; past the radius the factor is the far factor, else clamped at zero
    always_comb begin
        w_drop = EXT_W'(r_prod[PROD_W-1:DIV25_SH]);
        w_diff = EXT_W'(FAC_ONE) - w_drop;
        if (!r_near) begin
            n_factor = FAC_W'(FAR_FACTOR);
        end else if (w_drop >= EXT_W'(FAC_ONE)) begin
            n_factor = '0;
        end else begin
            n_factor = w_diff[FAC_W-1:0];
        end
    end

    assign w_scaled = SCL_W'(r_luma_e) * SCL_W'(r_factor);

    assign w_ld_f = !r_vld_f || i_rdy;
    assign w_ld_e = !r_vld_e || w_ld_f;
    assign w_ld_d = !r_vld_d || w_ld_e;
    assign o_rdy  = w_ld_d;

    // Valid bits of the three stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_d <= 1'b0;
            r_vld_e <= 1'b0;
            r_vld_f <= 1'b0;
        end else begin
            if (w_ld_d) r_vld_d <= i_vld;
            if (w_ld_e) r_vld_e <= r_vld_d;
            if (w_ld_f) r_vld_f <= r_vld_e;
        end
    end

    // Multiply by the reciprocal of 25
    always_ff @(posedge i_clk) begin
        if (w_ld_d && i_vld) begin
            r_prod   <= PROD_W'(w_num) * PROD_W'(DIV25_RECIP);
            r_near   <= w_near;
            r_luma_d <= i_luma;
        end
    end

    // Hold the factor
    always_ff @(posedge i_clk) begin
        if (w_ld_e && r_vld_d) begin
            r_factor <= n_factor;
            r_luma_e <= r_luma_d;
        end
    end

    // Scale and drop the factor's fraction bits
    always_ff @(posedge i_clk) begin
        if (w_ld_f && r_vld_e) begin
            r_out <= w_scaled[FAC_FRAC +: LUMA_W];
        end
    end

    assign o_vld  = r_vld_f;
    assign o_luma = r_out;
endmodule
`default_nettype wire

// ===== rtl/core/radial_spotlight_luminance.sv =====
// A result passes through 25 register stages, with one root bit per square root cell.
// Throughput: one item per cycle unless stalled; the square root is a row of 19 cells.
// Each stage moves on when the next one is empty or moving, so bubbles close up under stall.
// Reset (synchronous, active low) empties the pipeline and clears both center registers.
// Center registers are written through the plain write port and read by every item.
`default_nettype none
module radial_spotlight_luminance (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [rsl_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [rsl_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    rsl_in_if.sink                                  i_pix,
    rsl_out_if.source                               o_pix
);
    import rsl_pkg::*;

    logic signed [CTR_W-1:0] r_center_col;
    logic signed [CTR_W-1:0] r_center_row;
    logic [SQ_STEPS:0]       w_sq_vld;
    logic [SQ_STEPS:0]       w_sq_rdy;
    t_sq_data                w_sq_data [SQ_STEPS+1];

    // Write center registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_col <= '0;
            r_center_row <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CENTER_COL: r_center_col <= i_cfg_wdata[CTR_W-1:0];
                CFG_CENTER_ROW: r_center_row <= i_cfg_wdata[CTR_W-1:0];
                default: ;
            endcase
        end
    end

    rsl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_center_col (r_center_col),
        .i_center_row (r_center_row),
        .i_vld        (i_pix.valid),
        .o_rdy        (i_pix.ready),
        .i_col        (i_pix.pix_col),
        .i_row        (i_pix.pix_row),
        .i_luma       (i_pix.luma_in),
        .o_vld        (w_sq_vld[0]),
        .i_rdy        (w_sq_rdy[0]),
        .o_data       (w_sq_data[0])
    );

    // Chain of square root cells
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_cell
        rsl_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_sq_vld[g]),
            .o_rdy   (w_sq_rdy[g]),
            .i_data  (w_sq_data[g]),
            .o_vld   (w_sq_vld[g+1]),
            .i_rdy   (w_sq_rdy[g+1]),
            .o_data  (w_sq_data[g+1])
        );
    end

    rsl_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_sq_vld[SQ_STEPS]),
        .o_rdy   (w_sq_rdy[SQ_STEPS]),
        .i_dist  (w_sq_data[SQ_STEPS].root),
        .i_luma  (w_sq_data[SQ_STEPS].luma),
        .o_vld   (o_pix.valid),
        .i_rdy   (o_pix.ready),
        .o_luma  (o_pix.luma_out)
    );
endmodule
`default_nettype wire

// ===== rtl/core/rsl_checker.sv =====
// Port-level checks of the spotlight luminance block, bound to the top level.
`default_nettype none
module rsl_checker (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         i_in_ready,
    input wire logic                         i_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [rsl_pkg::LUMA_W-1:0]   i_luma_out
);
    import rsl_pkg::*;

    logic             w_in_acc;
    logic             w_out_acc;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    assign w_in_acc  = i_in_valid && i_in_ready;
    assign w_out_acc = i_out_valid && i_out_ready;
    assign n_cnt     = r_cnt + CNT_W'(w_in_acc) - CNT_W'(w_out_acc);

    // Track items in flight
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_luma_out)))
        else $error("stalled result changed or dropped");

    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_cnt != '0))
        else $error("result shown with no item in flight");

    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PIPE_DEPTH))
        else $error("more items in flight than pipeline stages");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 && !w_in_acc) |=> !i_out_valid)
        else $error("empty pipeline produced a result");
endmodule

bind radial_spotlight_luminance rsl_checker u_rsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_luma_out  (o_pix.luma_out)
);
`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for radial_spotlight_luminance: directed and random pixels checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import rsl_pkg::*;

    // Falloff rule as this testbench sees it
    localparam int unsigned SPOT_RADIUS  = 160;
    localparam int unsigned FAR_GAIN     = 13107;
    localparam int unsigned UNIT_GAIN    = 65536;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned TAIL_CYCLES  = 40;

    typedef struct {
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        logic [LUMA_W-1:0]     luma_in;
        logic [LUMA_W-1:0]     luma;
    } t_pixel;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    rsl_in_if  pix_in ();
    rsl_out_if pix_out ();

    radial_spotlight_luminance i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_in),
        .o_pix       (pix_out)
    );

    // Shadow copy of the center registers
    logic signed [CTR_W-1:0] ctr_col;
    logic signed [CTR_W-1:0] ctr_row;

    t_pixel luma_due[$];
    t_pixel head_item;
    int unsigned errors    = 0;
    int unsigned checked   = 0;
    int unsigned sent      = 0;
    int unsigned settings  = 0;
    int unsigned cycles    = 0;
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;
    int unsigned stall_left = 0;
    bit          calm      = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Floor square root, one root bit per pass from the top
    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned r;
        longint unsigned t;
        r = 0;
        for (int i = 21; i >= 0; i--) begin
            t = r | (longint'(1) << i);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    // Expected luminance for one pixel under the current center
    function automatic logic [LUMA_W-1:0] attenuate_luma(logic [COORD_BITS-1:0] col,
                                                         logic [COORD_BITS-1:0] row,
                                                         logic [LUMA_W-1:0] luma);
        longint dx;
        longint dy;
        longint unsigned span;
        longint unsigned drop;
        longint unsigned gain;
        dx = longint'(col) - longint'(ctr_col);
        dy = longint'(row) - longint'(ctr_row);
        span = floor_root(longint'(dx * dx + dy * dy) << 8);
        if (span <= SPOT_RADIUS * 16) begin
            drop = (512 * span + 24) / 25;
            gain = (drop >= UNIT_GAIN) ? 0 : UNIT_GAIN - drop;
        end else begin
            gain = FAR_GAIN;
        end
        return LUMA_W'((longint'(luma) * gain) >> 16);
    endfunction

    task automatic report_mismatch(string msg);
        if (errors < 40)
            $display("MISMATCH @%0t: %s", $realtime, msg);
        errors++;
    endtask

    // Send one pixel, optionally after an idle gap, and record its expected luminance
    task automatic send_pixel(logic [COORD_BITS-1:0] col, logic [COORD_BITS-1:0] row,
                              logic [LUMA_W-1:0] luma);
        int unsigned gap;
        t_pixel item;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 99) < gap_pct) begin
            gap = $urandom_range(1, 19);
            pix_in.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pix_in.valid   <= 1'b1;
        pix_in.pix_col <= col;
        pix_in.pix_row <= row;
        pix_in.luma_in <= luma;
        do @(posedge i_clk); while (pix_in.ready !== 1'b1);
        item.col     = col;
        item.row     = row;
        item.luma_in = luma;
        item.luma    = attenuate_luma(col, row, luma);
        luma_due.push_back(item);
        sent++;
    endtask

    // Drop valid and let the pipeline empty
    task automatic wait_idle();
        @(negedge i_clk);
        pix_in.valid <= 1'b0;
        while (luma_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Write both center registers; only called while the block is idle
    task automatic write_center(logic signed [CTR_W-1:0] col, logic signed [CTR_W-1:0] row);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_CENTER_COL;
        i_cfg_wdata <= col;
        @(negedge i_clk);
        i_cfg_idx   <= CFG_CENTER_ROW;
        i_cfg_wdata <= row;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        ctr_col = col;
        ctr_row = row;
        settings++;
    endtask

    // Keep a coordinate inside the image, else pick one at random
    function automatic logic [COORD_BITS-1:0] fold_coord(int v);
        if (v < 0 || v > 4095)
            return COORD_BITS'($urandom_range(0, 4095));
        return COORD_BITS'(v);
    endfunction

    function automatic logic [LUMA_W-1:0] rand_luma();
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4)
            return LUMA_W'($urandom_range(0, 65535));
        if (pick < 8)
            return LUMA_W'($urandom_range(0, 32768));
        case ($urandom_range(0, 2))
            0: return 16'd0;
            1: return 16'd32768;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Center at reset: zero distance keeps luma, far corner gets the flat gain
    task automatic test_reset_center();
        send_pixel(12'd0, 12'd0, 16'd32768);
        send_pixel(12'd0, 12'd0, 16'hFFFF);
        send_pixel(12'd0, 12'd0, 16'd0);
        send_pixel(12'd1, 12'd0, 16'hFFFF);
        send_pixel(12'd4095, 12'd4095, 16'd32768);
        wait_idle();
    endtask

    // Exactly at the radius and just past it, on both sides of the center
    task automatic test_falloff_edge();
        write_center(14'sd1000, 14'sd1000);
        send_pixel(12'd1160, 12'd1000, 16'hFFFF);
        send_pixel(12'd1160, 12'd1004, 16'hFFFF);
        send_pixel(12'd1160, 12'd1005, 16'hFFFF);
        send_pixel(12'd840, 12'd1000, 16'd32768);
        send_pixel(12'd1000, 12'd840, 16'd40000);
        send_pixel(12'd999, 12'd1001, 16'hAAAA);
        wait_idle();
    endtask

    // Centers at the register extremes, far outside the image
    task automatic test_far_centers();
        write_center(-14'sd8192, -14'sd8192);
        send_pixel(12'd4095, 12'd4095, 16'hFFFF);
        send_pixel(12'd0, 12'd0, 16'h5555);
        wait_idle();
        write_center(14'sd8191, 14'sd8191);
        send_pixel(12'd0, 12'd0, 16'hFFFF);
        send_pixel(12'd4095, 12'd4095, 16'hAAAA);
        wait_idle();
        write_center(-14'sd8192, 14'sd8191);
        send_pixel(12'd4095, 12'd0, 16'd32768);
        wait_idle();
    endtask

    // Random centers, one phase at the extremes; pixels cluster near the center and the falloff ring
    task automatic test_random_field(int unsigned phases, int unsigned per_phase);
        logic signed [CTR_W-1:0] cc;
        logic signed [CTR_W-1:0] cr;
        int unsigned kind;
        int sgn;
        logic [COORD_BITS-1:0] col;
        logic [COORD_BITS-1:0] row;
        for (int p = 0; p < phases; p++) begin
            wait_idle();
            if (p == 1) begin
                cc = 14'sd8191;
                cr = -14'sd8192;
            end else if ($urandom_range(0, 1) == 0) begin
                cc = CTR_W'($urandom_range(0, 4095));
                cr = CTR_W'($urandom_range(0, 4095));
            end else begin
                cc = CTR_W'($urandom_range(0, 16383));
                cr = CTR_W'($urandom_range(0, 16383));
            end
            write_center(cc, cr);
            case (p % 4)
                0: begin gap_pct = 25; stall_pct = 25; end
                1: begin gap_pct = 0;  stall_pct = 0;  end
                2: begin gap_pct = 10; stall_pct = 40; end
                default: begin gap_pct = 40; stall_pct = 10; end
            endcase
            calm = (p == phases - 1);
            for (int i = 0; i < per_phase; i++) begin
                kind = $urandom_range(0, 9);
                sgn  = ($urandom_range(0, 1) == 0) ? -1 : 1;
                if (kind < 5) begin
                    col = fold_coord(int'(cc) + int'($urandom_range(0, 340)) - 170);
                    row = fold_coord(int'(cr) + int'($urandom_range(0, 340)) - 170);
                end else if (kind < 7) begin
                    col = fold_coord(int'(cc) + sgn * int'($urandom_range(155, 165)));
                    row = fold_coord(int'(cr) + int'($urandom_range(0, 20)) - 10);
                end else begin
                    col = COORD_BITS'($urandom_range(0, 4095));
                    row = COORD_BITS'($urandom_range(0, 4095));
                end
                if ($urandom_range(0, 1) == 0)
                    send_pixel(col, row, rand_luma());
                else
                    send_pixel(row, col, rand_luma());
            end
        end
    endtask

    // Sink side: random stall bursts, none once the run goes calm
    always @(negedge i_clk) begin
        if (calm || stall_pct == 0) begin
            pix_out.ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            pix_out.ready <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left = $urandom_range(1, 19) - 1;
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= 1'b1;
        end
    end

    // Compare each delivered item with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
            if (luma_due.size() == 0) begin
                report_mismatch($sformatf("unexpected item, luma_out=%0d", pix_out.luma_out));
            end else begin
                head_item = luma_due.pop_front();
                checked++;
                if (pix_out.luma_out !== head_item.luma)
                    report_mismatch($sformatf(
                        "col=%0d row=%0d luma_in=%0d center=(%0d,%0d): luma_out=%0d, want %0d",
                        head_item.col, head_item.row, head_item.luma_in, ctr_col, ctr_row,
                        pix_out.luma_out, head_item.luma));
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d items still pending", cycles,
                     luma_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_CENTER_COL;
        i_cfg_wdata    = '0;
        pix_in.valid   = 1'b0;
        pix_in.pix_col = '0;
        pix_in.pix_row = '0;
        pix_in.luma_in = '0;
        pix_out.ready  = 1'b0;
        ctr_col        = '0;
        ctr_row        = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_center();
        test_falloff_edge();
        test_far_centers();
        test_random_field(6, 90);

        // Drain and give stray items a chance to show up
        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (luma_due.size() != 0)
            report_mismatch($sformatf("%0d expected items never arrived", luma_due.size()));

        $display("Sent %0d pixels over %0d center settings, checked %0d results.",
                 sent, settings, checked);
        $display("Covered radius edge, far and extreme centers, luma above 1.0; %0d mismatches.",
                 errors);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
`default_nettype wire

// ===== files.f =====
rtl/core/rsl_pkg.sv
rtl/core/rsl_in_if.sv
rtl/core/rsl_out_if.sv
rtl/core/rsl_sqrt_cell.sv
rtl/core/rsl_front.sv
rtl/core/rsl_back.sv
rtl/core/radial_spotlight_luminance.sv
rtl/core/rsl_checker.sv
sim/tb.sv
